FILE: hw/rtl/qzpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qzpm_pkg
// Shared types and constants for the quad zone point membership block.
// ----------------------------------------------------------------------------
package qzpm_pkg;

  localparam int MAX_QUADS_DEF = 16;
  localparam int LIST_CAP      = 16;
  localparam int COORD_W       = 32;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_LIST  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_QRD,
    ST_QCAP,
    ST_QDIF,
    ST_QMUL,
    ST_QCMP,
    ST_LRD,
    ST_LACC,
    ST_LOUT
  } state_t;

endpackage

FILE: hw/rtl/qzpm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qzpm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module qzpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/quad_zone_point_membership.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_zone_point_membership
// Quad table with an even-odd point membership test and center listing.
// Clear, dropped add, query or list on an empty table: result the cycle after
// the transaction, never busy. Add: busy while one corner per cycle is written.
// Query: per quad walked, fetch corner 3, then for each edge read, capture,
// difference, multiply and compare; stops at the first hit. List: one result
// per quad, strobed after its quad ends. Add and query strobe as busy drops.
// Reset empties the table; memory contents are not cleared.
// ----------------------------------------------------------------------------
module quad_zone_point_membership #(
  parameter int MAX_QUADS = qzpm_pkg::MAX_QUADS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic signed [31:0] corner0_x, corner0_y, corner1_x, corner1_y,
  input  logic signed [31:0] corner2_x, corner2_y, corner3_x, corner3_y,
  input  logic signed [31:0] point_x, point_y,
  output logic        strobe,
  output logic        inside_res,
  output logic        add_dropped,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic        center_valid,
  output logic        last
);

  localparam int DEPTH = 4 * MAX_QUADS;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = $clog2(MAX_QUADS + 1);
  localparam int QIW   = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;

  qzpm_pkg::state_t state, state_next;
  logic           strobe_next;

  logic [QW-1:0]  quad_count;
  logic [QIW-1:0] qidx;
  logic [1:0]     cidx;
  logic [31:0]    c_x [4];
  logic [31:0]    c_y [4];
  logic signed [31:0] px, py;
  logic signed [31:0] xi, yi, xj, yj;
  logic signed [32:0] dxt, dy, dxe, dyt;
  logic signed [65:0] lprod, rprod;
  logic           have_prev, parity, straddle, d_pos;
  logic signed [33:0] sum_x, sum_y;

  logic           we;
  logic [AW-1:0]  addr;
  logic [31:0]    wdx, wdy, rdx, rdy;

  logic           tbl_full;
  logic [QW:0]    qnum;
  logic           q_last, last_quad, crossing, parity_next;

  qzpm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(we), .addr(addr), .wdata(wdx), .rdata(rdx));
  qzpm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(we), .addr(addr), .wdata(wdy), .rdata(rdy));

  // stored order 0,1,3,2 of Z order
  always_comb begin
    wdx = c_x[cidx];
    wdy = c_y[cidx];
  end

  assign addr = AW'({qidx, cidx});
  assign we   = (state == qzpm_pkg::ST_ADD);
  assign busy = (state != qzpm_pkg::ST_IDLE);

  assign tbl_full  = (quad_count >= QW'(MAX_QUADS));
  assign qnum      = (QW+1)'(qidx) + (QW+1)'(1);
  assign q_last    = (qnum >= (QW+1)'(quad_count));
  assign last_quad = q_last || (int'(qnum) >= qzpm_pkg::LIST_CAP);

  // edge i..j; cross if (tx-xi)*d < (xj-xi)*(ty-yi), flipped when d<=0
  assign crossing    = d_pos ? (lprod < rprod) : (rprod < lprod);
  assign parity_next = parity ^ (straddle && crossing);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= qzpm_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_comb begin
    state_next  = state;
    strobe_next = 1'b0;
    case (state)
      qzpm_pkg::ST_IDLE: if (start) begin
        case (qzpm_pkg::op_t'(op))
          qzpm_pkg::OP_CLEAR: strobe_next = 1'b1;
          qzpm_pkg::OP_ADD: begin
            if (tbl_full) strobe_next = 1'b1;
            else state_next = qzpm_pkg::ST_ADD;
          end
          qzpm_pkg::OP_QUERY: begin
            if (quad_count == '0) strobe_next = 1'b1;
            else state_next = qzpm_pkg::ST_QRD;
          end
          default: begin
            if (quad_count == '0) strobe_next = 1'b1;
            else state_next = qzpm_pkg::ST_LRD;
          end
        endcase
      end
      qzpm_pkg::ST_ADD: if (cidx == 2'd3) begin
        state_next  = qzpm_pkg::ST_IDLE;
        strobe_next = 1'b1;
      end
      qzpm_pkg::ST_QRD:  state_next = qzpm_pkg::ST_QCAP;
      qzpm_pkg::ST_QCAP: state_next = have_prev ? qzpm_pkg::ST_QDIF : qzpm_pkg::ST_QRD;
      qzpm_pkg::ST_QDIF: state_next = qzpm_pkg::ST_QMUL;
      qzpm_pkg::ST_QMUL: state_next = qzpm_pkg::ST_QCMP;
      qzpm_pkg::ST_QCMP: begin
        if (cidx == 2'd3 && (parity_next || q_last)) begin
          state_next  = qzpm_pkg::ST_IDLE;
          strobe_next = 1'b1;
        end else begin
          state_next = qzpm_pkg::ST_QRD;
        end
      end
      qzpm_pkg::ST_LRD:  state_next = qzpm_pkg::ST_LACC;
      qzpm_pkg::ST_LACC: state_next = (cidx == 2'd3) ? qzpm_pkg::ST_LOUT
                                                     : qzpm_pkg::ST_LRD;
      qzpm_pkg::ST_LOUT: begin
        strobe_next = 1'b1;
        state_next  = last_quad ? qzpm_pkg::ST_IDLE : qzpm_pkg::ST_LRD;
      end
      default: state_next = qzpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_count   <= '0;
      qidx         <= '0;
      cidx         <= '0;
      have_prev    <= 1'b0;
      parity       <= 1'b0;
      inside_res   <= 1'b0;
      add_dropped  <= 1'b0;
      center_valid <= 1'b0;
      center_x     <= '0;
      center_y     <= '0;
      last         <= 1'b0;
    end else begin
      case (state)
        qzpm_pkg::ST_IDLE: if (start) begin
          inside_res <= 1'b0; center_valid <= 1'b0;
          add_dropped <= (qzpm_pkg::op_t'(op) == qzpm_pkg::OP_ADD) && tbl_full;
          center_x <= '0; center_y <= '0; last <= 1'b1;
          qidx <= (qzpm_pkg::op_t'(op) == qzpm_pkg::OP_ADD) ? QIW'(quad_count) : '0;
          // a query fetches corner 3 first as the wrap edge start
          cidx <= (qzpm_pkg::op_t'(op) == qzpm_pkg::OP_QUERY) ? 2'd3 : 2'd0;
          have_prev <= 1'b0; parity <= 1'b0;
          px <= point_x; py <= point_y;
          sum_x <= '0; sum_y <= '0;
          c_x[0] <= corner0_x; c_x[1] <= corner1_x;
          c_x[2] <= corner3_x; c_x[3] <= corner2_x;
          c_y[0] <= corner0_y; c_y[1] <= corner1_y;
          c_y[2] <= corner3_y; c_y[3] <= corner2_y;
          if (qzpm_pkg::op_t'(op) == qzpm_pkg::OP_CLEAR) quad_count <= '0;
        end
        qzpm_pkg::ST_ADD: begin
          cidx <= cidx + 2'd1;
          if (cidx == 2'd3) quad_count <= quad_count + QW'(1);
        end
        qzpm_pkg::ST_QCAP: begin
          if (!have_prev) begin
            xj <= signed'(rdx); yj <= signed'(rdy);
            have_prev <= 1'b1;
            cidx <= cidx + 2'd1;
          end else begin
            xi <= signed'(rdx); yi <= signed'(rdy);
          end
        end
        qzpm_pkg::ST_QDIF: begin
          straddle <= (yi > py) != (yj > py);
          d_pos    <= (yj > yi);
          dxt      <= 33'(px) - 33'(xi);
          dy       <= 33'(yj) - 33'(yi);
          dxe      <= 33'(xj) - 33'(xi);
          dyt      <= 33'(py) - 33'(yi);
        end
        qzpm_pkg::ST_QMUL: begin
          lprod <= dxt * dy;
          rprod <= dxe * dyt;
        end
        qzpm_pkg::ST_QCMP: begin
          xj <= xi; yj <= yi;
          if (cidx == 2'd3) begin
            have_prev <= 1'b0;
            if (parity_next || q_last) begin
              inside_res <= parity_next;
              parity     <= parity_next;
            end else begin
              qidx   <= qidx + QIW'(1);
              parity <= 1'b0;
            end
          end else begin
            cidx   <= cidx + 2'd1;
            parity <= parity_next;
          end
        end
        qzpm_pkg::ST_LACC: begin
          sum_x <= sum_x + 34'(signed'(rdx));
          sum_y <= sum_y + 34'(signed'(rdy));
          cidx <= cidx + 2'd1;
        end
        qzpm_pkg::ST_LOUT: begin
          center_x <= sum_x[33:2]; center_y <= sum_y[33:2];
          center_valid <= 1'b1;
          last <= last_quad;
          sum_x <= '0; sum_y <= '0;
          qidx <= qidx + QIW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/qzpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qzpm_checker
// Port-level checks for the quad zone point membership block.
// ----------------------------------------------------------------------------
module qzpm_checker (
  input logic clk, rst, start, busy, strobe, last, center_valid,
  input logic inside_res, add_dropped
);
  a_one_hot_fields: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(inside_res && add_dropped)) else $error("two answers set");
  a_valid_center_only: assert property (@(posedge clk) disable iff (rst)
    strobe && center_valid |-> !inside_res && !add_dropped)
    else $error("center mixed with answers");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy) else $error("busy after final result");
  a_no_strobe_idle_start: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("partial list while idle");
endmodule

bind quad_zone_point_membership qzpm_checker u_qzpm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .last(last), .center_valid(center_valid), .inside_res(inside_res),
  .add_dropped(add_dropped));
